### hw/rtl/rtcot_pkg.sv
// Shared types, constants and helper functions for the RTC offset time registers.
`default_nettype none

package rtcot_pkg;

   typedef enum logic {
      CMD_READ  = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      FIELD_SEC    = 3'd0,
      FIELD_MIN    = 3'd1,
      FIELD_HOUR   = 3'd2,
      FIELD_DAY_LO = 3'd3,
      FIELD_DAY_HI = 3'd4
   } field_sel_type;

   // Per-transfer sideband that rides along the split pipeline.
   typedef struct packed {
      cmd_type       cmd;
      field_sel_type sel;
      logic [7:0]    value;
   } rtcot_tag_type;

   // Elapsed time broken into clock fields.
   typedef struct packed {
      logic [5:0]  sec;
      logic [5:0]  min;
      logic [4:0]  hour;
      logic [15:0] days;
   } rtcot_fields_type;

   localparam logic [31:0] SECS_PER_MIN      = 32'd60;
   localparam logic [31:0] SECS_PER_HOUR     = 32'd3600;
   localparam logic [31:0] SECS_PER_DAY      = 32'd86400;
   localparam logic [31:0] SECS_PER_256_DAYS = 32'd22118400;

   // Reciprocals for exact floor division: x/60 = (x>>2)/15, x/24 = (x>>3)/3.
   localparam logic [30:0] RECIP_15_K34 = 31'd1145324613;  // ceil(2^34/15), x < 2^30
   localparam logic [24:0] RECIP_15_K28 = 25'd17895698;    // ceil(2^28/15), x < 19173961
   localparam logic [18:0] RECIP_3_K20  = 19'd349526;      // ceil(2^20/3),  x < 2^18

   // Byte modulo 60 by restoring subtraction.
   function automatic logic [5:0] mod60_byte(input logic [7:0] v);
      logic [7:0] r;
      r = v;
      if (r >= 8'd240) r = r - 8'd240;
      if (r >= 8'd120) r = r - 8'd120;
      if (r >= 8'd60)  r = r - 8'd60;
      return r[5:0];
   endfunction

   // Byte modulo 24 by restoring subtraction.
   function automatic logic [4:0] mod24_byte(input logic [7:0] v);
      logic [7:0] r;
      r = v;
      if (r >= 8'd192) r = r - 8'd192;
      if (r >= 8'd96)  r = r - 8'd96;
      if (r >= 8'd48)  r = r - 8'd48;
      if (r >= 8'd24)  r = r - 8'd24;
      return r[4:0];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/rtcot_split.sv
// Four-stage pipeline that splits elapsed seconds into sec/min/hour/day fields.
`default_nettype none

module rtcot_split
   import rtcot_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic             in_valid,
   input  wire rtcot_tag_type    in_tag,
   input  wire logic [31:0]      in_elapsed,
   output logic                  out_valid,
   output rtcot_tag_type         out_tag,
   output rtcot_fields_type      out_fields,
   output logic                  write_pending
);

   logic [3:0]          valid_ff;
   rtcot_tag_type       tag_ff [4];

   logic [31:0]         s1_elapsed_ff;
   logic [5:0]          s2_elapsed_ff;
   logic [26:0]         s2_q1_ff;
   logic [20:0]         s3_q2_ff;
   logic [5:0]          s3_q1_lo_ff;
   logic [5:0]          s3_sec_ff;
   logic [15:0]         s4_days_ff;
   logic [4:0]          s4_q2_lo_ff;
   logic [5:0]          s4_min_ff;
   logic [5:0]          s4_sec_ff;

   logic [60:0]         prod1;
   logic [49:0]         prod2;
   logic [36:0]         prod3;
   logic [5:0]          sec_in;
   logic [5:0]          min_in;

   assign prod1 = s1_elapsed_ff[31:2] * RECIP_15_K34;   // q1 = E / 60
   assign prod2 = s2_q1_ff[26:2] * RECIP_15_K28;         // q2 = q1 / 60
   assign prod3 = s3_q2_ff[20:3] * RECIP_3_K20;          // days = q2 / 24

   // Remainders only need low bits: 60 = 64 - 4, so x - 60q = x + 4q mod 64.
   assign sec_in = s2_elapsed_ff + {s2_q1_ff[3:0], 2'b00};
   assign min_in = s3_q1_lo_ff + {s3_q2_ff[3:0], 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff[0]     <= in_tag;
         tag_ff[1]     <= tag_ff[0];
         tag_ff[2]     <= tag_ff[1];
         tag_ff[3]     <= tag_ff[2];
         s1_elapsed_ff <= in_elapsed;
         s2_elapsed_ff <= s1_elapsed_ff[5:0];
         s2_q1_ff      <= prod1[60:34];
         s3_q2_ff      <= prod2[48:28];
         s3_q1_lo_ff   <= s2_q1_ff[5:0];
         s3_sec_ff     <= sec_in;
         s4_days_ff    <= prod3[35:20];
         s4_q2_lo_ff   <= s3_q2_ff[4:0];
         s4_min_ff     <= min_in;
         s4_sec_ff     <= s3_sec_ff;
      end
   end

   always_comb begin
      write_pending = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (valid_ff[i] && (tag_ff[i].cmd == CMD_WRITE)) write_pending = 1'b1;
      end
   end

   // 24 = 32 - 8, so q2 - 24*days = q2 + 8*days mod 32.
   assign out_fields.sec  = s4_sec_ff;
   assign out_fields.min  = s4_min_ff;
   assign out_fields.hour = s4_q2_lo_ff + {s4_days_ff[1:0], 3'b000};
   assign out_fields.days = s4_days_ff;
   assign out_valid       = valid_ff[3];
   assign out_tag         = tag_ff[3];

endmodule

`default_nettype wire

### hw/rtl/rtc_offset_time_registers.sv
// Top level of the RTC offset time registers: offset state, field pipeline, response register.
// Usage:
//   Request channel (req_*): cmd selects read or write of one clock field
//   (seconds, minutes, hours, day low byte, day bit 8) chosen by field_select,
//   with write_value for writes and now_seconds as the free-running wall time.
//   Response channel (rsp_*): one transfer of read_value per read; writes
//   give no response. Unused selectors read 0 and ignore writes.
//   Elapsed time is now_seconds minus a 32-bit offset, wrapping mod 2^32.
// Read path: a read's request transfer loads the elapsed-time register;
//   the read then passes three reciprocal-multiply stages and the response
//   register before it shows on rsp_valid.
// Flow: reads go back to back, one per cycle while the response side does
//   not stall. A write changes the offset that every later request needs,
//   so req_stall stays high while a write is in the four pipeline stages.
// Stall: when rsp_valid is high and rsp_stall is high, the whole pipeline
//   holds and req_stall rises; nothing is lost or repeated.
// Reset: synchronous; clears the offset to 0 and empties the pipeline.
`default_nettype none

module rtc_offset_time_registers
   import rtcot_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_cmd,
   input  wire logic [2:0]  req_field_select,
   input  wire logic [7:0]  req_write_value,
   input  wire logic [31:0] req_now_seconds,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_read_value
);

   logic              advance;
   logic              req_transfer;
   logic              write_pending;
   logic              fin_valid;
   rtcot_tag_type     in_tag;
   rtcot_tag_type     fin_tag;
   rtcot_fields_type  fin_fields;

   logic [31:0]       offset_ff;
   logic [31:0]       offset_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [7:0]        rsp_read_value_ff;
   logic [7:0]        read_mux;
   logic [31:0]       delta;
   logic [5:0]        val_mod60;
   logic [4:0]        val_mod24;
   logic              fin_write;
   logic              fin_read;

   // Whole pipeline moves together whenever the response register can take data.
   assign advance      = !rsp_valid_ff || !rsp_stall;
   // No new request while a write is in flight: it would see a stale offset.
   assign req_stall    = !advance || write_pending;
   assign req_transfer = req_valid && !req_stall;

   assign in_tag.cmd   = cmd_type'(req_cmd);
   assign in_tag.sel   = field_sel_type'(req_field_select);
   assign in_tag.value = req_write_value;

   rtcot_split u_split (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (req_transfer),
      .in_tag        (in_tag),
      .in_elapsed    (req_now_seconds - offset_ff),
      .out_valid     (fin_valid),
      .out_tag       (fin_tag),
      .out_fields    (fin_fields),
      .write_pending (write_pending)
   );

   assign fin_write = fin_valid && (fin_tag.cmd == CMD_WRITE);
   assign fin_read  = fin_valid && (fin_tag.cmd == CMD_READ);
   assign val_mod60 = mod60_byte(fin_tag.value);
   assign val_mod24 = mod24_byte(fin_tag.value);

   // Read mux.
   always_comb begin
      unique case (fin_tag.sel)
         FIELD_SEC:    read_mux = {2'b00, fin_fields.sec};
         FIELD_MIN:    read_mux = {2'b00, fin_fields.min};
         FIELD_HOUR:   read_mux = {3'b000, fin_fields.hour};
         FIELD_DAY_LO: read_mux = fin_fields.days[7:0];
         FIELD_DAY_HI: read_mux = {7'd0, fin_fields.days[8]};
         default:      read_mux = 8'd0;
      endcase
   end

   // A write replaces one field: new elapsed = old + (new - old field) * weight.
   // Since elapsed = now - offset, the offset simply drops by that amount.
   // Day bit 8 write also clears the day bits above it.
   always_comb begin
      unique case (fin_tag.sel)
         FIELD_SEC:    delta = {26'd0, val_mod60} - {26'd0, fin_fields.sec};
         FIELD_MIN:    delta = ({26'd0, val_mod60} - {26'd0, fin_fields.min})
                               * SECS_PER_MIN;
         FIELD_HOUR:   delta = ({27'd0, val_mod24} - {27'd0, fin_fields.hour})
                               * SECS_PER_HOUR;
         FIELD_DAY_LO: delta = ({24'd0, fin_tag.value} - {24'd0, fin_fields.days[7:0]})
                               * SECS_PER_DAY;
         FIELD_DAY_HI: delta = ({31'd0, fin_tag.value[0]} - {24'd0, fin_fields.days[15:8]})
                               * SECS_PER_256_DAYS;
         default:      delta = 32'd0;
      endcase
   end

   always_comb begin
      offset_in    = offset_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = fin_read;
         if (fin_write) offset_in = offset_ff - delta;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && fin_read) rsp_read_value_ff <= read_mux;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;

endmodule

`default_nettype wire

### dv/tb_rtc_offset_time_registers.sv
// Self-checking testbench for the RTC offset time registers: directed and random traffic.
`default_nettype none

module tb_rtc_offset_time_registers
   import rtcot_pkg::*;
;

   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          NUM_SELECTORS = 8;    // every code of the 3-bit selector
   localparam int          MAX_IDLE      = 16;   // longest sender gap per transfer
   localparam int          DRAIN_CYCLES  = 12;   // read pipeline is 5 deep
   localparam int          MAX_REPORTS   = 10;
   localparam logic [31:0] BASE60        = 32'd60;
   localparam logic [31:0] BASE24        = 32'd24;

   // Idling phases
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_phase_type;

   typedef struct {
      logic [2:0] sel;
      logic [7:0] value;
   } field_read_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_cmd;
   logic [2:0]  req_field_select;
   logic [7:0]  req_write_value;
   logic [31:0] req_now_seconds;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_read_value;

   // Predicted state and expected read data, oldest first
   logic [31:0]    clock_offset;
   field_read_type pending_reads[$];

   int sender_idle_pct;
   int rsp_stall_pct;
   int items_sent;
   int reads_checked;
   int writes_applied;
   int failures;
   int cycle_count;

   logic [31:0] wall_clock;   // running "now" for well-formed traffic

   rtc_offset_time_registers DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_field_select (req_field_select),
      .req_write_value  (req_write_value),
      .req_now_seconds  (req_now_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_value   (rsp_read_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Clock-field arithmetic, all unsigned 32-bit and wrapping
   // ---------------------------------------------------------------------

   function automatic logic [7:0] clock_field(input logic [2:0] sel, input logic [31:0] elapsed);
      logic [31:0] q;
      logic [7:0]  r;
      r = 8'd0;
      case (sel)
         FIELD_SEC: begin
            q = elapsed % BASE60;
            r = q[7:0];
         end
         FIELD_MIN: begin
            q = (elapsed / SECS_PER_MIN) % BASE60;
            r = q[7:0];
         end
         FIELD_HOUR: begin
            q = (elapsed / SECS_PER_HOUR) % BASE24;
            r = q[7:0];
         end
         FIELD_DAY_LO: begin
            q = elapsed / SECS_PER_DAY;
            r = q[7:0];   // low byte of the day count
         end
         FIELD_DAY_HI: begin
            q = elapsed / SECS_PER_256_DAYS;
            r = {7'd0, q[0]};
         end
         default: r = 8'd0;   // no field behind this selector
      endcase
      return r;
   endfunction

   // Elapsed time after a field write; other fields kept (day bit 8 clears higher days).
   function automatic logic [31:0] elapsed_after_write(input logic [2:0] sel,
                                                       input logic [31:0] elapsed,
                                                       input logic [7:0] value);
      logic [31:0] v;
      logic [31:0] e;
      v = {24'd0, value};
      e = elapsed;
      case (sel)
         FIELD_SEC:
            e = (elapsed / SECS_PER_MIN) * SECS_PER_MIN + v % BASE60;
         FIELD_MIN:
            e = (elapsed / SECS_PER_HOUR) * SECS_PER_HOUR + (v % BASE60) * SECS_PER_MIN
                + elapsed % SECS_PER_MIN;
         FIELD_HOUR:
            e = (elapsed / SECS_PER_DAY) * SECS_PER_DAY + (v % BASE24) * SECS_PER_HOUR
                + elapsed % SECS_PER_HOUR;
         FIELD_DAY_LO:
            e = (elapsed / SECS_PER_256_DAYS) * SECS_PER_256_DAYS + v * SECS_PER_DAY
                + elapsed % SECS_PER_DAY;
         FIELD_DAY_HI:
            e = (v[0] ? SECS_PER_256_DAYS : 32'd0) + elapsed % SECS_PER_256_DAYS;
         default:
            e = elapsed;   // unused selector: offset unchanged
      endcase
      return e;
   endfunction

   // Update the predicted offset, or queue the expected read data.
   task automatic track_access(input cmd_type cmd, input logic [2:0] sel,
                               input logic [7:0] value, input logic [31:0] now);
      logic [31:0]    elapsed;
      field_read_type rd;
      elapsed = now - clock_offset;
      if (cmd == CMD_READ) begin
         rd.sel   = sel;
         rd.value = clock_field(sel, elapsed);
         pending_reads.push_back(rd);
      end else begin
         clock_offset = now - elapsed_after_write(sel, elapsed, value);
         writes_applied++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Drives one request and returns at the edge where it transfers.
   // Valid stays high into the next call unless that call opens a gap.
   task automatic send_access(input cmd_type cmd, input logic [2:0] sel,
                              input logic [7:0] value, input logic [31:0] now);
      int idle;
      idle = 0;
      while (idle < MAX_IDLE && $urandom_range(99) < sender_idle_pct) idle++;
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_field_select <= sel;
      req_write_value  <= value;
      req_now_seconds  <= now;
      do @(posedge clock); while (req_stall);
      track_access(cmd, sel, value, now);
      items_sent++;
   endtask

   // Hold off the sender until every outstanding read has come back.
   task automatic wait_for_reads();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_reads.size() != 0);
   endtask

   task automatic set_idling(input idle_phase_type phase);
      case (phase)
         IDLE_NONE:     begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
         IDLE_SENDER:   begin sender_idle_pct = 67; rsp_stall_pct = 0;  end
         IDLE_RECEIVER: begin sender_idle_pct = 0;  rsp_stall_pct = 67; end
         default:       begin sender_idle_pct = 7;  rsp_stall_pct = 7;  end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Offset is 0 after reset, so elapsed equals now: all-ones and zero time.
   task automatic test_field_extremes();
      for (int s = 0; s < NUM_SELECTORS; s++)
         send_access(CMD_READ, 3'(s), 8'hff, 32'hffff_ffff);
      send_access(CMD_READ, FIELD_SEC, 8'h00, 32'h0000_0000);
   endtask

   // Full-scale byte into every field, each read back right away.
   task automatic test_write_readback();
      for (int s = FIELD_SEC; s <= FIELD_DAY_HI; s++) begin
         send_access(CMD_WRITE, 3'(s), 8'hff, 32'h8000_0000);
         send_access(CMD_READ, 3'(s), 8'h00, 32'h8000_0001);
      end
   endtask

   // Writes to selectors without a field must leave the offset alone.
   task automatic test_unused_select();
      for (int s = FIELD_DAY_HI + 1; s < NUM_SELECTORS; s++)
         send_access(CMD_WRITE, 3'(s), 8'h5a, 32'h1234_5678);
      send_access(CMD_READ, FIELD_MIN, 8'h00, 32'h1234_5679);
   endtask

   // Setting day bit 8 at now = 0 pushes the offset past now; elapsed wraps.
   task automatic test_elapsed_wrap();
      send_access(CMD_WRITE, FIELD_DAY_HI, 8'h01, 32'h0000_0000);
      send_access(CMD_READ, FIELD_DAY_HI, 8'h00, 32'h0000_0005);
   endtask

   // Well-formed traffic: a field write on a running clock, then a few reads.
   task automatic test_clock_sequences(input int count);
      int          last;
      int          nreads;
      logic [2:0]  sel;
      last = items_sent + count;
      while (items_sent < last) begin
         if ($urandom_range(15) == 0)
            wall_clock = $urandom();   // clock jump
         sel = ($urandom_range(7) == 0) ? 3'($urandom_range(NUM_SELECTORS - 1))
                                        : 3'($urandom_range(FIELD_DAY_HI));
         wall_clock += $urandom_range(3);
         send_access(CMD_WRITE, sel, 8'($urandom_range(255)), wall_clock);
         nreads = $urandom_range(1, 3);
         for (int i = 0; i < nreads; i++) begin
            wall_clock += $urandom_range(3);
            if (i == 0 || $urandom_range(1) == 0)
               send_access(CMD_READ, sel, 8'($urandom_range(255)), wall_clock);
            else
               send_access(CMD_READ, 3'($urandom_range(FIELD_DAY_HI)),
                           8'($urandom_range(255)), wall_clock);
         end
      end
   endtask

   // Unstructured requests: any command, selector, byte and time.
   task automatic test_random_noise(input int count);
      for (int i = 0; i < count; i++)
         send_access(cmd_type'($urandom_range(1)), 3'($urandom_range(NUM_SELECTORS - 1)),
                     8'($urandom_range(255)), $urandom());
   endtask

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      field_read_type exp_rd;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reads.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("ERROR: unexpected response, read_value %0h", rsp_read_value);
         end else begin
            exp_rd = pending_reads.pop_front();
            reads_checked++;
            if (rsp_read_value !== exp_rd.value) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("ERROR: read of field %0d: expected %0h, got %0h",
                           exp_rd.sel, exp_rd.value, rsp_read_value);
            end
         end
      end
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d reads outstanding",
               cycle_count, pending_reads.size());
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_cmd          <= CMD_READ;
      req_field_select <= FIELD_SEC;
      req_write_value  <= 8'd0;
      req_now_seconds  <= 32'd0;
      clock_offset     = 32'd0;
      items_sent       = 0;
      reads_checked    = 0;
      writes_applied   = 0;
      failures         = 0;
      wall_clock       = $urandom();
      set_idling(IDLE_NONE);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_write_readback();
      test_unused_select();
      test_elapsed_wrap();
      wait_for_reads();

      for (int p = IDLE_NONE; p <= IDLE_BOTH; p++) begin
         set_idling(idle_phase_type'(p));
         test_clock_sequences(240);
         test_random_noise(60);
         wait_for_reads();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_reads.size() != 0)
         failures++;

      $display("Covered %0d transfers (%0d writes, %0d reads checked) over four idling phases,",
               items_sent, writes_applied, reads_checked);
      $display("including wrapped elapsed time and unused selectors; %0d failures",
               failures);
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/rtcot_pkg.sv
hw/rtl/rtcot_split.sv
hw/rtl/rtc_offset_time_registers.sv
dv/tb_rtc_offset_time_registers.sv
